// ----- design/jsu_pkg.sv -----
// Shared types, constants and helpers for the JSON string unescape block.
// Used by jsu_decode and json_string_unescape_utf8; no dependencies.
package jsu_pkg;

    localparam int unsigned MaxResults = 4;
    localparam int unsigned CntW       = $clog2(MaxResults + 1);

    // Error codes carried with a result word
    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_CTRL_CHAR = 3'd1,
        ERR_BAD_ESC   = 3'd2,
        ERR_BAD_HEX   = 3'd3,
        ERR_UNP_HIGH  = 3'd4,
        ERR_UNP_LOW   = 3'd5
    } t_err;

    // Characters of interest
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CTRL_LIM = 8'd32;

    // Surrogate tags in the top six bits of a code unit
    localparam logic [5:0] SURR_HIGH = 6'b110110;
    localparam logic [5:0] SURR_LOW  = 6'b110111;

    // Group of result words caused by one input byte
    typedef struct packed {
        logic [CntW-1:0]             cnt;
        logic [MaxResults-1:0][7:0]  bytes;
        logic                        has;
        logic                        eos;
        t_err                        err;
    } t_res;

    typedef struct packed {
        logic [CntW-1:0]             cnt;
        logic [MaxResults-1:0][7:0]  bytes;
    } t_utf8;

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'b10000;
        if (b >= 8'h30 && b <= 8'h39) r = {1'b0, b[3:0]};
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
            r = {1'b0, b[3:0] + 4'd9};
        return r;
    endfunction

    function automatic t_utf8 utf8_encode(input logic [20:0] cp);
        t_utf8 u;
        u = '0;
        if (cp < 21'h80) begin
            u.cnt      = CntW'(1);
            u.bytes[0] = {1'b0, cp[6:0]};
        end else if (cp < 21'h800) begin
            u.cnt      = CntW'(2);
            u.bytes[0] = {3'b110, cp[10:6]};
            u.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.cnt      = CntW'(3);
            u.bytes[0] = {4'b1110, cp[15:12]};
            u.bytes[1] = {2'b10, cp[11:6]};
            u.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            u.cnt      = CntW'(4);
            u.bytes[0] = {5'b11110, cp[20:18]};
            u.bytes[1] = {2'b10, cp[17:12]};
            u.bytes[2] = {2'b10, cp[11:6]};
            u.bytes[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

endpackage

// ----- design/jsu_decode.sv -----
// Escape decoder state machine: one raw byte per step, result group out.
// Depends on jsu_pkg.
module jsu_decode
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    input  logic       i_first,
    output t_res       o_res
);

    typedef enum logic [2:0] {
        PH_NORMAL   = 3'd0,
        PH_ESC      = 3'd1,
        PH_HEX1     = 3'd2,
        PH_WANT_BSL = 3'd3,
        PH_WANT_U   = 3'd4,
        PH_HEX2     = 3'd5
    } t_phase;

    t_phase       r_phase, n_phase, ph;
    logic [1:0]   r_dc, n_dc, dc;
    logic [15:0]  r_acc, n_acc, acc;
    logic [9:0]   r_hb, n_hb, hb;
    logic         r_halt, n_halt, halt;

    logic [4:0]   hex;
    logic [15:0]  acc_new;
    logic [20:0]  cp;
    t_utf8        enc;
    t_res         res;

    always_comb begin
        ph   = i_first ? PH_NORMAL : r_phase;
        dc   = i_first ? 2'd0 : r_dc;
        acc  = i_first ? 16'd0 : r_acc;
        hb   = i_first ? 10'd0 : r_hb;
        halt = i_first ? 1'b0 : r_halt;
    end

    assign hex     = hex_digit(i_byte);
    assign acc_new = {acc[11:0], hex[3:0]};
    // pair: ((hb << 10) | lo) + 0x10000
    assign cp      = (ph == PH_HEX2) ? {({1'b0, hb[9:6]} + 5'd1), hb[5:0], acc_new[9:0]}
                                     : {5'd0, acc_new};
    assign enc     = utf8_encode(cp);

    always_comb begin
        n_phase = ph;
        n_dc    = dc;
        n_acc   = acc;
        n_hb    = hb;
        n_halt  = halt;
        res     = '0;
        res.err = ERR_NONE;
        if (!halt) begin
            unique case (ph)
                PH_ESC: begin
                    n_phase = PH_NORMAL;
                    res.cnt = CntW'(1);
                    res.has = 1'b1;
                    unique case (i_byte)
                        CH_SLASH, CH_QUOTE, CH_BSL: res.bytes[0] = i_byte;
                        CH_B: res.bytes[0] = 8'h08;
                        CH_T: res.bytes[0] = 8'h09;
                        CH_N: res.bytes[0] = 8'h0A;
                        CH_F: res.bytes[0] = 8'h0C;
                        CH_R: res.bytes[0] = 8'h0D;
                        CH_U: begin
                            n_phase = PH_HEX1;
                            n_dc    = 2'd0;
                            n_acc   = 16'd0;
                            res     = '0;
                        end
                        default: begin
                            n_halt  = 1'b1;
                            res.has = 1'b0;
                            res.err = ERR_BAD_ESC;
                        end
                    endcase
                end
                PH_HEX1, PH_HEX2: begin
                    if (hex[4]) begin
                        n_halt  = 1'b1;
                        n_phase = PH_NORMAL;
                        res.cnt = CntW'(1);
                        res.err = (ph == PH_HEX1) ? ERR_BAD_HEX : ERR_UNP_HIGH;
                    end else begin
                        n_acc = acc_new;
                        if (dc != 2'd3) begin
                            n_dc = dc + 2'd1;
                        end else begin
                            n_dc    = 2'd0;
                            n_phase = PH_NORMAL;
                            if (ph == PH_HEX1 && acc_new[15:10] == SURR_HIGH) begin
                                n_hb    = acc_new[9:0];
                                n_phase = PH_WANT_BSL;
                            end else if ((ph == PH_HEX1 && acc_new[15:10] == SURR_LOW) ||
                                         (ph == PH_HEX2 && acc_new[15:10] != SURR_LOW)) begin
                                n_halt  = 1'b1;
                                res.cnt = CntW'(1);
                                res.err = (ph == PH_HEX1) ? ERR_UNP_LOW : ERR_UNP_HIGH;
                            end else begin
                                res.cnt   = enc.cnt;
                                res.bytes = enc.bytes;
                                res.has   = 1'b1;
                            end
                        end
                    end
                end
                PH_WANT_BSL, PH_WANT_U: begin
                    if (i_byte != ((ph == PH_WANT_BSL) ? CH_BSL : CH_U)) begin
                        n_halt  = 1'b1;
                        n_phase = PH_NORMAL;
                        res.cnt = CntW'(1);
                        res.err = ERR_UNP_HIGH;
                    end else if (ph == PH_WANT_BSL) begin
                        n_phase = PH_WANT_U;
                    end else begin
                        n_phase = PH_HEX2;
                        n_dc    = 2'd0;
                        n_acc   = 16'd0;
                    end
                end
                default: begin
                    n_phase = PH_NORMAL;
                    res.cnt = CntW'(1);
                    if (i_byte == CH_QUOTE) begin
                        n_halt  = 1'b1;
                        res.eos = 1'b1;
                    end else if (i_byte < CTRL_LIM) begin
                        n_halt  = 1'b1;
                        res.err = ERR_CTRL_CHAR;
                    end else if (i_byte == CH_BSL) begin
                        n_phase = PH_ESC;
                        res.cnt = '0;
                    end else begin
                        res.has      = 1'b1;
                        res.bytes[0] = i_byte;
                    end
                end
            endcase
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_NORMAL;
            r_dc    <= 2'd0;
            r_acc   <= 16'd0;
            r_hb    <= 10'd0;
            r_halt  <= 1'b0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_dc    <= n_dc;
            r_acc   <= n_acc;
            r_hb    <= n_hb;
            r_halt  <= n_halt;
        end
    end

endmodule

// ----- design/json_string_unescape_utf8.sv -----
// Top level: JSON string body unescape to UTF-8, stream in and stream out.
// Depends on jsu_pkg and jsu_decode.
//
//  channel  dir  word                       handshake
//  s_axis   in   byte_in, first (tuser)     tvalid & tready
//  m_axis   out  out_byte, flags (tuser)    tvalid & tready, tlast ends a byte's group
//
// One input word per cycle while the output is not stalled and each byte yields at
// most one result word; a \u escape that yields k UTF-8 bytes stalls s_axis while
// the result group drains through the output register.
// Synchronous active-low reset clears decoder state and both stages.
// Output stalls back up into the input register, then into s_axis_tready.
module json_string_unescape_utf8
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tuser,   // [0] first
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [4:0] m_axis_tuser,   // [0] has_byte, [1] end_of_string, [4:2] error_code
    output logic       m_axis_tlast    // last
);

    logic                       r_in_valid;
    logic [7:0]                 r_in_byte;
    logic                       r_in_first;

    logic [CntW-1:0]            r_cnt;
    logic [MaxResults-1:0][7:0] r_byte;
    logic                       r_has;
    logic                       r_eos;
    t_err                       r_err;

    logic out_take, grp_free, step;
    t_res res;

    assign out_take      = m_axis_tvalid && m_axis_tready;
    assign grp_free      = (r_cnt == '0) || (r_cnt == CntW'(1) && out_take);
    assign step          = r_in_valid && grp_free;
    assign s_axis_tready = !r_in_valid || grp_free;

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .i_first (r_in_first),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (step) begin
            r_cnt <= res.cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= res.bytes;
            r_has  <= res.has;
            r_eos  <= res.eos;
            r_err  <= res.err;
        end else if (out_take) begin
            r_byte <= {8'h00, r_byte[MaxResults-1:1]};
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_byte[0];
    assign m_axis_tuser  = {r_err, r_eos, r_has};
    assign m_axis_tlast  = (r_cnt == CntW'(1));

endmodule

// ----- verif/jsu_utf8_checker.sv -----
`timescale 1ns / 1ps
// Checker for json_string_unescape_utf8: decodes every accepted input word into the
// UTF-8 result words it should cause and compares them against the output stream.
// Depends on jsu_pkg for error codes, character and surrogate constants.
module jsu_utf8_checker
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    input  logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tuser,   // [0] first
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
    input  logic [4:0] m_axis_tuser,   // [0] has_byte, [1] end_of_string, [4:2] error_code
    input  logic       m_axis_tlast,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_words_checked,
    output int         o_closed,
    output int         o_failed
);

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_ESC,
        PH_HEX_FIRST,
        PH_WANT_BSL,
        PH_WANT_U,
        PH_HEX_SECOND
    } t_phase;

    typedef struct packed {
        logic [7:0] data;
        logic       has;
        logic       eos;
        t_err       err;
        logic       last;
    } t_word;

    t_phase      phase;
    logic [1:0]  ndigits;
    logic [15:0] unit;
    logic [9:0]  high_bits;
    logic        halted;
    t_word       utf8_q[$];
    int          fail_cnt;
    int          checked_cnt;
    int          closed_cnt;
    int          failed_cnt;

    function automatic void push_word(logic [7:0] data, logic has, logic eos, t_err err,
                                      logic last);
        t_word w;
        w = '{data, has, eos, err, last};
        utf8_q.push_back(w);
    endfunction

    function automatic void end_with(t_err code);
        halted = 1'b1;
        phase  = PH_TEXT;
        failed_cnt++;
        push_word(8'h00, 1'b0, 1'b0, code, 1'b1);
    endfunction

    function automatic int hex_value(logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
        if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h57;
        if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h37;
        return -1;
    endfunction

    function automatic void emit_code(logic [20:0] cp);
        phase = PH_TEXT;
        if (cp < 21'h80) begin
            push_word(cp[7:0], 1'b1, 1'b0, ERR_NONE, 1'b1);
        end else if (cp < 21'h800) begin
            push_word(8'hC0 | 8'(cp >> 6), 1'b1, 1'b0, ERR_NONE, 1'b0);
            push_word(8'h80 | 8'(cp & 21'h3F), 1'b1, 1'b0, ERR_NONE, 1'b1);
        end else if (cp < 21'h10000) begin
            push_word(8'hE0 | 8'(cp >> 12), 1'b1, 1'b0, ERR_NONE, 1'b0);
            push_word(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, 1'b0, ERR_NONE, 1'b0);
            push_word(8'h80 | 8'(cp & 21'h3F), 1'b1, 1'b0, ERR_NONE, 1'b1);
        end else begin
            push_word(8'hF0 | 8'((cp >> 18) & 21'h7), 1'b1, 1'b0, ERR_NONE, 1'b0);
            push_word(8'h80 | 8'((cp >> 12) & 21'h3F), 1'b1, 1'b0, ERR_NONE, 1'b0);
            push_word(8'h80 | 8'((cp >> 6) & 21'h3F), 1'b1, 1'b0, ERR_NONE, 1'b0);
            push_word(8'h80 | 8'(cp & 21'h3F), 1'b1, 1'b0, ERR_NONE, 1'b1);
        end
    endfunction

    function automatic void clear_state();
        phase     = PH_TEXT;
        ndigits   = '0;
        unit      = '0;
        high_bits = '0;
        halted    = 1'b0;
    endfunction

    function automatic void decode_byte(logic [7:0] b, logic first);
        int h;
        if (first) clear_state();
        if (halted) return;
        case (phase)
            PH_ESC: begin
                phase = PH_TEXT;
                case (b)
                    CH_SLASH, CH_QUOTE, CH_BSL: push_word(b, 1'b1, 1'b0, ERR_NONE, 1'b1);
                    CH_B: push_word(8'h08, 1'b1, 1'b0, ERR_NONE, 1'b1);
                    CH_T: push_word(8'h09, 1'b1, 1'b0, ERR_NONE, 1'b1);
                    CH_N: push_word(8'h0A, 1'b1, 1'b0, ERR_NONE, 1'b1);
                    CH_F: push_word(8'h0C, 1'b1, 1'b0, ERR_NONE, 1'b1);
                    CH_R: push_word(8'h0D, 1'b1, 1'b0, ERR_NONE, 1'b1);
                    CH_U: begin
                        phase   = PH_HEX_FIRST;
                        ndigits = '0;
                        unit    = '0;
                    end
                    default: end_with(ERR_BAD_ESC);
                endcase
            end
            PH_HEX_FIRST, PH_HEX_SECOND: begin
                h = hex_value(b);
                if (h < 0) begin
                    if (phase == PH_HEX_FIRST) end_with(ERR_BAD_HEX);
                    else end_with(ERR_UNP_HIGH);
                end else begin
                    unit = {unit[11:0], 4'(h)};
                    if (ndigits != 2'd3) begin
                        ndigits = ndigits + 2'd1;
                    end else begin
                        ndigits = '0;
                        if (phase == PH_HEX_FIRST) begin
                            if (unit[15:10] == SURR_HIGH) begin
                                high_bits = unit[9:0];
                                phase     = PH_WANT_BSL;
                            end else if (unit[15:10] == SURR_LOW) begin
                                end_with(ERR_UNP_LOW);
                            end else begin
                                emit_code({5'd0, unit});
                            end
                        end else if (unit[15:10] != SURR_LOW) begin
                            end_with(ERR_UNP_HIGH);
                        end else begin
                            emit_code(21'h10000 + {1'b0, high_bits, unit[9:0]});
                        end
                    end
                end
            end
            PH_WANT_BSL: begin
                if (b != CH_BSL) end_with(ERR_UNP_HIGH);
                else phase = PH_WANT_U;
            end
            PH_WANT_U: begin
                if (b != CH_U) begin
                    end_with(ERR_UNP_HIGH);
                end else begin
                    phase   = PH_HEX_SECOND;
                    ndigits = '0;
                    unit    = '0;
                end
            end
            default: begin
                phase = PH_TEXT;
                if (b == CH_QUOTE) begin
                    halted = 1'b1;
                    closed_cnt++;
                    push_word(8'h00, 1'b0, 1'b1, ERR_NONE, 1'b1);
                end else if (b < CTRL_LIM) begin
                    end_with(ERR_CTRL_CHAR);
                end else if (b == CH_BSL) begin
                    phase = PH_ESC;
                end else begin
                    push_word(b, 1'b1, 1'b0, ERR_NONE, 1'b1);
                end
            end
        endcase
    endfunction

    function automatic int field_diff(string name, int want, int got);
        if (want == got) return 0;
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_word got;
        t_word want;
        if (!i_rst_n) begin
            clear_state();
            utf8_q.delete();
            fail_cnt    = 0;
            checked_cnt = 0;
            closed_cnt  = 0;
            failed_cnt  = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) decode_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1],
                        t_err'(m_axis_tuser[4:2]), m_axis_tlast};
                checked_cnt++;
                if (utf8_q.size() == 0) begin
                    $error("output word 0x%0h with nothing expected", got);
                    fail_cnt++;
                end else begin
                    want = utf8_q.pop_front();
                    fail_cnt += field_diff("out_byte", want.data, got.data);
                    fail_cnt += field_diff("has_byte", want.has, got.has);
                    fail_cnt += field_diff("end_of_string", want.eos, got.eos);
                    fail_cnt += field_diff("error_code", want.err, got.err);
                    fail_cnt += field_diff("last", want.last, got.last);
                end
            end
        end
        o_fail_count    <= fail_cnt;
        o_pending       <= utf8_q.size();
        o_words_checked <= checked_cnt;
        o_closed        <= closed_cnt;
        o_failed        <= failed_cnt;
    end

endmodule

// ----- verif/json_string_unescape_utf8_tb.sv -----
`timescale 1ns / 1ps
// Top of the json_string_unescape_utf8 testbench: builds string bodies with escapes,
// surrogate pairs and error endings and streams them with random gaps and stalls.
// Depends on jsu_pkg, the block and jsu_utf8_checker, which does the checking.
module json_string_unescape_utf8_tb;
    import jsu_pkg::*;

    localparam int RandomItems = 320;
    localparam int CycleLimit  = 200000;
    localparam int LongHold    = 80;
    localparam int Settle      = 16;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_in;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] byte_in
    logic       s_axis_tuser;   // [0] first
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [7:0] out_byte
    logic [4:0] m_axis_tuser;   // [0] has_byte, [1] end_of_string, [4:2] error_code
    logic       m_axis_tlast;

    int  fail_count;
    int  pending;
    int  words_checked;
    int  closed;
    int  failed;
    int  cycles;
    int  nstrings;
    int  counted;
    bit  sink_idle;
    bit  hold_req;
    t_in feed_q[$];
    logic [7:0] body_q[$];

    json_string_unescape_utf8 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    jsu_utf8_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .m_axis_tlast    (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_words_checked (words_checked),
        .o_closed        (closed),
        .o_failed        (failed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic void add(logic [7:0] b);
        body_q.push_back(b);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        if (nib < 10) return 8'h30 + nib;
        return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 10);
    endfunction

    function automatic bit is_hex(logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    function automatic void add_unit(logic [15:0] u);
        add(CH_BSL);
        add(CH_U);
        for (int k = 3; k >= 0; k--) add(hex_char(u[4*k +: 4]));
    endfunction

    function automatic void add_digits_then_junk();
        logic [7:0] b;
        repeat ($urandom_range(0, 3)) add(hex_char(4'($urandom_range(0, 15))));
        do b = 8'($urandom_range(0, 255)); while (is_hex(b));
        add(b);
    endfunction

    // Range ends are favored so code point boundaries come up often
    function automatic logic [15:0] pick_code(int lo, int hi);
        if ($urandom_range(0, 3) == 0) return 16'($urandom_range(0, 1) ? lo : hi);
        return 16'($urandom_range(hi, lo));
    endfunction

    function automatic logic [7:0] simple_escape();
        case ($urandom_range(0, 7))
            0: return CH_SLASH;
            1: return CH_QUOTE;
            2: return CH_BSL;
            3: return CH_B;
            4: return CH_T;
            5: return CH_N;
            6: return CH_F;
            default: return CH_R;
        endcase
    endfunction

    function automatic void add_token();
        logic [7:0]  b;
        logic [15:0] u;
        case ($urandom_range(0, 9))
            4, 5: begin
                add(CH_BSL);
                add(simple_escape());
            end
            6: add_unit(pick_code('h0, 'h7F));
            7: add_unit(pick_code('h80, 'h7FF));
            8: begin
                u = pick_code('h800, 'hFFFF);
                if (u[15:11] == 5'b11011) u = u ^ 16'h2000;
                add_unit(u);
            end
            9: begin
                add_unit(pick_code('hD800, 'hDBFF));
                add_unit(pick_code('hDC00, 'hDFFF));
            end
            default: begin
                do b = 8'($urandom_range(32, 255)); while (b == CH_QUOTE || b == CH_BSL);
                add(b);
            end
        endcase
    endfunction

    // Returns 1 if the body was left open (cut short), 0 if it ends the string
    function automatic bit add_ending();
        logic [7:0]  b;
        logic [15:0] u;
        case ($urandom_range(0, 15))
            9: add(8'($urandom_range(0, 31)));
            10: begin
                add(CH_BSL);
                do b = 8'($urandom_range(0, 255));
                while (b inside {CH_SLASH, CH_QUOTE, CH_BSL, CH_B, CH_T, CH_N, CH_F, CH_R, CH_U});
                add(b);
            end
            11: begin
                add(CH_BSL);
                add(CH_U);
                add_digits_then_junk();
            end
            12: add_unit(pick_code('hDC00, 'hDFFF));
            13: begin
                add_unit(pick_code('hD800, 'hDBFF));
                case ($urandom_range(0, 3))
                    0: begin
                        do b = 8'($urandom_range(0, 255)); while (b == CH_BSL);
                        add(b);
                    end
                    1: begin
                        add(CH_BSL);
                        do b = 8'($urandom_range(0, 255)); while (b == CH_U);
                        add(b);
                    end
                    2: begin
                        add(CH_BSL);
                        add(CH_U);
                        add_digits_then_junk();
                    end
                    default: begin
                        do u = 16'($urandom_range(0, 'hFFFF)); while (u[15:10] == SURR_LOW);
                        add_unit(u);
                    end
                endcase
            end
            14, 15: begin
                add(CH_BSL);
                if ($urandom_range(0, 1)) begin
                    add(CH_U);
                    repeat ($urandom_range(0, 3)) add(hex_char(4'($urandom_range(0, 15))));
                end
                return 1'b1;
            end
            default: add(CH_QUOTE);
        endcase
        return 1'b0;
    endfunction

    function automatic void flush_body();
        foreach (body_q[k]) feed_q.push_back('{body_q[k], k == 0});
        counted += body_q.size();
        body_q.delete();
        nstrings++;
    endfunction

    function automatic void build_directed();
        add(8'h20);
        add(8'hFF);
        add(CH_BSL);
        add(CH_N);
        add_unit(16'hDBFF);
        add_unit(16'hDFFF);
        add(CH_QUOTE);
        flush_body();
        add(8'h00);
        flush_body();
        feed_q.push_back('{8'h41, 1'b0});   // ignored while halted
        add_unit(16'h0000);
        add(8'h1F);
        flush_body();
    endfunction

    function automatic void build_random();
        bit open;
        counted = 0;
        while (counted < RandomItems) begin
            repeat ($urandom_range(0, 10)) add_token();
            open = add_ending();
            flush_body();
            if (!open) begin
                repeat ($urandom_range(0, 2)) feed_q.push_back('{8'($urandom_range(0, 255)), 1'b0});
            end
        end
    endfunction

    initial begin
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        m_axis_tready <= 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LongHold) @(posedge i_clk);
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin
        int  pressure_at;
        int  quiet_from;
        bit  calm;
        bit  pressing;
        cycles        = 0;
        nstrings      = 0;
        sink_idle     = 1'b0;
        hold_req      = 1'b0;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        build_directed();
        pressure_at = feed_q.size() + 60;
        build_random();
        quiet_from = feed_q.size() * 85 / 100;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < feed_q.size(); i++) begin
            calm     = i >= quiet_from;
            pressing = i >= pressure_at && i < pressure_at + 60;
            if (i == pressure_at) hold_req = 1'b1;
            sink_idle = !calm && (i % 64) >= 16;
            if (!calm && !pressing && (i % 80) < 50 && $urandom_range(0, 4) == 0) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= feed_q[i].data;
            s_axis_tuser  <= feed_q[i].first;
            // inputs and tready only move at rising edges, so the falling edge is safe
            do @(negedge i_clk); while (!s_axis_tready);
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
        $display("Streamed %0d strings as %0d input words; %0d output words checked.",
                 nstrings, feed_q.size(), words_checked);
        $display("Strings closed by a quote: %0d, ended by a decode error: %0d.",
                 closed, failed);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            if (pending != 0) $error("%0d expected words never arrived", pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/jsu_pkg.sv
design/jsu_decode.sv
design/json_string_unescape_utf8.sv
verif/jsu_utf8_checker.sv
verif/json_string_unescape_utf8_tb.sv
